@@ sv/rlsp_pkg.sv @@
// Package with the character codes, error codes and request kinds of the range list parser.
`timescale 1ns / 1ps

package rlsp_pkg;

  // Characters that the parser recognizes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Sticky error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_EMPTY     = 3'd2;
  localparam logic [2:0] ERR_ORDER     = 3'd3;
  localparam logic [2:0] ERR_ZERO_END  = 3'd4;
  localparam logic [2:0] ERR_JUNK      = 3'd5;
  localparam logic [2:0] ERR_ENDING    = 3'd6;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd7;

  // Request kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

endpackage

@@ sv/range_list_selection_parser_unit.sv @@
// Range list selection parser: string parsing into a count memory and ordered read-out.
`timescale 1ns / 1ps

// The block takes a selection string such as "1,4-7,9" one character per request and
// counts every selected index in a count memory of MAX_INDEX entries with registered
// read data. Drain requests return the selected indices in ascending order, repeated by
// their count when keep_duplicates is set, and clear each entry as it is drained. After
// reset the block sweeps every memory entry to zero before it takes a request. Every
// index that a character records costs a memory read, then a write back, so a range a-b
// visits each entry from a to b. A drain request that scans reads each memory entry in
// turn until it finds a nonzero count, or runs past the last entry and reports the end
// of the read-out.
module range_list_selection_parser_unit
  import rlsp_pkg::*;
#(
  parameter int MAX_INDEX   = 1024,
  parameter int COUNT_WIDTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_error_code,
  output logic       out_index_valid,
  output logic [9:0] out_selected_index,
  output logic       out_drain_done
);

  localparam int IW = $clog2(MAX_INDEX);
  localparam int AW = $clog2(MAX_INDEX + 1);
  localparam int CW = COUNT_WIDTH;
  localparam logic [AW-1:0] MAX_A  = AW'(MAX_INDEX);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_INDEX - 1);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_BUMP_RD, S_BUMP_WR, S_SCAN_RD, S_SCAN_CK, S_FIN
  } state_t;

  typedef enum logic {PH_FIRST, PH_RANGE} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic          have_r, have_nxt;
  logic [AW-1:0] rbeg_r, rbeg_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [AW-1:0] dptr_r, dptr_nxt;
  logic [CW-1:0] rep_r, rep_nxt;
  logic          keep_r;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic          res_iv_r, res_iv_nxt;
  logic [AW-1:0] res_sel_r, res_sel_nxt;
  logic          res_done_r, res_done_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_err_r, out_err_nxt;
  logic          out_iv_r, out_iv_nxt;
  logic [9:0]    out_sel_r, out_sel_nxt;
  logic          out_done_r, out_done_nxt;

  // Count memory ports.
  logic [CW-1:0] cnt_mem [MAX_INDEX];
  logic          mem_re;
  logic [IW-1:0] mem_ra;
  logic [CW-1:0] mem_rd_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [CW-1:0] mem_wd;

  // Character decode and accumulator update.
  logic          is_digit;
  logic [7:0]    dig_off;
  logic [AW+3:0] acc_prod;
  logic [AW-1:0] acc_dig;
  logic          accept;

  assign accept   = in_valid && in_ready;
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign dig_off  = in_char_code - CH_ZERO;
  assign acc_prod = {4'b0, acc_r} * (AW + 4)'(10) + (AW + 4)'(dig_off[3:0]);
  assign acc_dig  = (acc_prod > (AW + 4)'(MAX_INDEX)) ? MAX_A : acc_prod[AW-1:0];

  // Parse step: works out the error, the store update and the new parse state.
  logic          pe_fin, pe_sgl;
  logic [AW-1:0] pe_b, pe_e;
  logic [2:0]    pe_err;
  logic          pe_bump;
  logic [AW-1:0] pe_lo, pe_hi;
  phase_t        pe_ph;
  logic [AW-1:0] pe_acc, pe_rb;
  logic          pe_hv;

  always_comb begin
    pe_fin  = 1'b0;
    pe_sgl  = 1'b0;
    pe_b    = '0;
    pe_e    = '0;
    pe_err  = ERR_NONE;
    pe_bump = 1'b0;
    pe_lo   = '0;
    pe_hi   = '0;
    pe_ph   = phase_r;
    pe_acc  = acc_r;
    pe_rb   = rbeg_r;
    pe_hv   = have_r;
    if (err_r == ERR_NONE) begin
      if (is_digit) begin
        pe_acc = acc_dig;
        pe_hv  = 1'b1;
        if (in_last_char) begin
          if (phase_r == PH_RANGE) begin
            pe_fin = 1'b1;
            pe_b   = rbeg_r;
            pe_e   = acc_dig;
          end else begin
            pe_sgl = 1'b1;
            pe_e   = acc_dig;
          end
        end
      end else if (phase_r == PH_RANGE) begin
        pe_fin = 1'b1;
        pe_b   = rbeg_r;
        pe_e   = have_r ? acc_r : '0;
        pe_ph  = PH_FIRST;
        pe_acc = '0;
        pe_hv  = 1'b0;
      end else if (in_char_code == CH_COMMA) begin
        if (have_r) begin
          pe_sgl = 1'b1;
          pe_e   = acc_r;
          pe_acc = '0;
          pe_hv  = 1'b0;
        end else begin
          pe_err = ERR_EMPTY;
        end
      end else if (in_char_code == CH_MINUS) begin
        pe_rb  = have_r ? acc_r : '0;
        pe_acc = '0;
        pe_hv  = 1'b0;
        pe_ph  = PH_RANGE;
      end else begin
        pe_err = ERR_BAD_CHAR;
      end
      // Range and single checks.
      if (pe_fin) begin
        if (pe_b >= MAX_A || pe_e >= MAX_A) begin
          pe_err = ERR_TOO_LARGE;
        end else if (pe_b > pe_e) begin
          pe_err = ERR_ORDER;
        end else if (pe_e == '0) begin
          pe_err = ERR_ZERO_END;
        end else begin
          pe_bump = 1'b1;
          pe_lo   = pe_b;
          pe_hi   = pe_e;
        end
        if (!is_digit && in_char_code != CH_COMMA && pe_err == ERR_NONE) begin
          pe_err = ERR_JUNK;
        end
      end
      if (pe_sgl) begin
        if (pe_e >= MAX_A) begin
          pe_err = ERR_TOO_LARGE;
        end else begin
          pe_bump = 1'b1;
          pe_lo   = pe_e;
          pe_hi   = pe_e;
        end
      end
      if (in_last_char && !is_digit && pe_err == ERR_NONE) begin
        pe_err = ERR_ENDING;
      end
    end
    // The end of the string restarts the parser.
    if (in_last_char) begin
      pe_ph  = PH_FIRST;
      pe_acc = '0;
      pe_hv  = 1'b0;
      pe_rb  = '0;
    end
  end

  // Sequencer next-state logic and memory port control.
  logic [CW-1:0] rep_dec;
  logic [31:0]   sel_ext;

  assign rep_dec = rep_r - CW'(1);
  assign sel_ext = 32'(res_sel_r);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    have_nxt      = have_r;
    rbeg_nxt      = rbeg_r;
    err_nxt       = err_r;
    dptr_nxt      = dptr_r;
    rep_nxt       = rep_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    res_iv_nxt    = res_iv_r;
    res_sel_nxt   = res_sel_r;
    res_done_nxt  = res_done_r;
    out_err_nxt   = out_err_r;
    out_iv_nxt    = out_iv_r;
    out_sel_nxt   = out_sel_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_re = 1'b0;
    mem_ra = p_r[IW-1:0];
    mem_we = 1'b0;
    mem_wa = p_r[IW-1:0];
    mem_wd = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (p_r == LAST_A) begin
          p_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          p_nxt = p_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_iv_nxt   = 1'b0;
          res_sel_nxt  = '0;
          res_done_nxt = 1'b0;
          if (in_kind == KIND_CHAR) begin
            phase_nxt = pe_ph;
            acc_nxt   = pe_acc;
            have_nxt  = pe_hv;
            rbeg_nxt  = pe_rb;
            if (pe_err != ERR_NONE) begin
              err_nxt = pe_err;
            end
            if (pe_bump) begin
              p_nxt     = pe_lo;
              hi_nxt    = pe_hi;
              state_nxt = S_BUMP_RD;
            end else begin
              state_nxt = S_FIN;
            end
          end else if (rep_r != '0 && dptr_r < MAX_A) begin
            rep_nxt     = rep_dec;
            res_iv_nxt  = 1'b1;
            res_sel_nxt = dptr_r;
            if (rep_dec == '0) begin
              dptr_nxt = dptr_r + AW'(1);
            end
            state_nxt = S_FIN;
          end else begin
            rep_nxt   = '0;
            p_nxt     = dptr_r;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_BUMP_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_BUMP_WR;
      end
      S_BUMP_WR: begin
        mem_we = 1'b1;
        mem_wd = (mem_rd_r == CNT_MAX) ? mem_rd_r : mem_rd_r + CW'(1);
        if (p_r == hi_r) begin
          state_nxt = S_FIN;
        end else begin
          p_nxt     = p_r + AW'(1);
          state_nxt = S_BUMP_RD;
        end
      end
      S_SCAN_RD: begin
        if (p_r >= MAX_A) begin
          res_done_nxt = 1'b1;
          dptr_nxt     = '0;
          state_nxt    = S_FIN;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (mem_rd_r == '0) begin
          p_nxt     = p_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          mem_we      = 1'b1;
          rep_nxt     = keep_r ? mem_rd_r - CW'(1) : '0;
          res_iv_nxt  = 1'b1;
          res_sel_nxt = p_r;
          if (keep_r && mem_rd_r != CW'(1)) begin
            dptr_nxt = p_r;
          end else begin
            dptr_nxt = p_r + AW'(1);
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_iv_nxt    = res_iv_r;
          out_sel_nxt   = sel_ext[9:0];
          out_done_nxt  = res_done_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_FIRST;
      acc_r       <= '0;
      have_r      <= 1'b0;
      rbeg_r      <= '0;
      err_r       <= ERR_NONE;
      dptr_r      <= '0;
      rep_r       <= '0;
      keep_r      <= 1'b0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      have_r      <= have_nxt;
      rbeg_r      <= rbeg_nxt;
      err_r       <= err_nxt;
      dptr_r      <= dptr_nxt;
      rep_r       <= rep_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
    end
    hi_r       <= hi_nxt;
    res_iv_r   <= res_iv_nxt;
    res_sel_r  <= res_sel_nxt;
    res_done_r <= res_done_nxt;
    out_err_r  <= out_err_nxt;
    out_iv_r   <= out_iv_nxt;
    out_sel_r  <= out_sel_nxt;
    out_done_r <= out_done_nxt;
  end

  // Count memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= cnt_mem[mem_ra];
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_error_code     = out_err_r;
  assign out_index_valid    = out_iv_r;
  assign out_selected_index = out_sel_r;
  assign out_drain_done     = out_done_r;

  // A sticky error never changes until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |=> (err_r == $past(err_r)))
    else $error("sticky error changed");

  // A result never reports an index and the end of the read-out together.
  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_iv_r && out_done_r))
    else $error("index and drain done both set");

  // The memory is never written while the block waits for a request.
  a_no_idle_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write in idle");

  // Pending repeats always point at a stored index.
  a_rep_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_r != '0) |-> (dptr_r < MAX_A))
    else $error("repeat count without a valid pointer");

endmodule
